FILE: rtl/fat2_pkg.sv
// ----------------------------------------------------------------------------
// fat2_pkg: shared types, constants and arctangent table
// Widths, turn offsets and the octant arctangent table used by the atan2 chain.
// ----------------------------------------------------------------------------
package fat2_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int DIV_STEPS    = FRAC_BITS + 1;
    localparam int SEG_SHIFT    = FRAC_BITS - 4;
    localparam int QUARTER_TURN = 1 << (FRAC_BITS - 2);
    localparam int HALF_TURN    = 1 << (FRAC_BITS - 1);

    typedef logic [16:0] mag_t;    // magnitude 0..32768
    typedef logic [14:0] quot_t;   // Q14 tangent 0..16384
    typedef logic [11:0] oct_t;    // octant angle 0..2048
    typedef logic [7:0]  slope_t;  // table step between two entries

    typedef struct packed {
        logic sneg;   // sine component negative
        logic cneg;   // cosine component negative
        logic swap;   // |sine| > |cosine|, operands exchanged
        logic zero;   // both components zero
    } fat2_flags_t;

    function automatic oct_t octant_entry(input logic [4:0] idx);
        oct_t v;
        case (idx)
            5'd0:    v = 12'd0;
            5'd1:    v = 12'd163;
            5'd2:    v = 12'd324;
            5'd3:    v = 12'd483;
            5'd4:    v = 12'd639;
            5'd5:    v = 12'd790;
            5'd6:    v = 12'd936;
            5'd7:    v = 12'd1075;
            5'd8:    v = 12'd1209;
            5'd9:    v = 12'd1336;
            5'd10:   v = 12'd1457;
            5'd11:   v = 12'd1571;
            5'd12:   v = 12'd1678;
            5'd13:   v = 12'd1779;
            5'd14:   v = 12'd1874;
            5'd15:   v = 12'd1964;
            5'd16:   v = 12'd2048;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/fat2_fold.sv
// ----------------------------------------------------------------------------
// fat2_fold: fold input vector into the first octant
// Takes magnitudes, orders them so y <= x and records quadrant flags.
// ----------------------------------------------------------------------------
module fat2_fold (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [15:0]   sine_value,
    input  logic signed [15:0]   cosine_value,
    output logic                 valid_reg,
    output fat2_pkg::mag_t       y_reg,
    output fat2_pkg::mag_t       x_reg,
    output fat2_pkg::fat2_flags_t flags_reg
);
    import fat2_pkg::*;

    logic signed [16:0] s_ext;
    logic signed [16:0] c_ext;
    mag_t               ms;
    mag_t               mc;
    logic               swap;
    mag_t               y_next;
    mag_t               x_next;
    fat2_flags_t        flags_next;

    always_comb
    begin
        s_ext = {sine_value[15], sine_value};
        c_ext = {cosine_value[15], cosine_value};
        ms    = sine_value[15]   ? mag_t'(-s_ext) : mag_t'(s_ext);
        mc    = cosine_value[15] ? mag_t'(-c_ext) : mag_t'(c_ext);
        swap  = (ms > mc);
        y_next = swap ? mc : ms;
        x_next = swap ? ms : mc;
        flags_next.sneg = sine_value[15];
        flags_next.cneg = cosine_value[15];
        flags_next.swap = swap;
        flags_next.zero = (x_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg     <= y_next;
            x_reg     <= x_next;
            flags_reg <= flags_next;
        end
    end

endmodule

FILE: rtl/fat2_div_cell.sv
// ----------------------------------------------------------------------------
// fat2_div_cell: one restoring division step
// Compares the partial remainder with the divisor, appends one quotient bit
// and hands remainder, divisor, quotient and flags to the next cell.
// ----------------------------------------------------------------------------
module fat2_div_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  fat2_pkg::mag_t        rem_in,
    input  fat2_pkg::mag_t        x_in,
    input  fat2_pkg::quot_t       q_in,
    input  fat2_pkg::fat2_flags_t flags_in,
    output logic                  valid_reg,
    output fat2_pkg::mag_t        rem_reg,
    output fat2_pkg::mag_t        x_reg,
    output fat2_pkg::quot_t       q_reg,
    output fat2_pkg::fat2_flags_t flags_reg
);
    import fat2_pkg::*;

    logic        ge;
    mag_t        diff;
    logic [15:0] kept;
    mag_t        rem_next;
    quot_t       q_next;

    always_comb
    begin
        ge       = (rem_in >= x_in);
        diff     = rem_in - x_in;
        // remainder after the step is below the divisor, so 16 bits hold it
        kept     = ge ? diff[15:0] : rem_in[15:0];
        rem_next = {kept, 1'b0};
        q_next   = {q_in[DIV_STEPS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg   <= rem_next;
            x_reg     <= x_in;
            q_reg     <= q_next;
            flags_reg <= flags_in;
        end
    end

endmodule

FILE: rtl/fat2_interp.sv
// ----------------------------------------------------------------------------
// fat2_interp: table lookup and linear interpolation
// Splits the tangent into segment and weight, looks up the table, then adds
// the weighted step to the lower entry (floor).
// ----------------------------------------------------------------------------
module fat2_interp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  fat2_pkg::quot_t       t_in,
    input  fat2_pkg::fat2_flags_t flags_in,
    output logic                  valid_reg,
    output fat2_pkg::oct_t        a_reg,
    output fat2_pkg::fat2_flags_t flags_reg
);
    import fat2_pkg::*;

    logic [3:0]  seg;
    quot_t       frac;
    oct_t        lo;
    oct_t        hi;
    oct_t        lo_next;
    slope_t      slope_next;

    logic        lk_valid_reg;
    oct_t        lo_reg;
    slope_t      slope_reg;
    quot_t       frac_reg;
    fat2_flags_t lk_flags_reg;

    logic [22:0] prod;
    oct_t        a_next;

    always_comb
    begin
        // tangent of exactly one clamps to the last segment at full weight
        seg  = t_in[FRAC_BITS] ? 4'd15 : t_in[FRAC_BITS-1:SEG_SHIFT];
        frac = t_in[FRAC_BITS] ? quot_t'(1 << FRAC_BITS)
                               : {1'b0, t_in[SEG_SHIFT-1:0], 4'b0000};
        lo   = octant_entry({1'b0, seg});
        hi   = octant_entry(5'({1'b0, seg} + 5'd1));
        lo_next    = flags_in.zero ? '0 : lo;
        slope_next = flags_in.zero ? '0 : slope_t'(hi - lo);
    end

    always_comb
    begin
        prod   = 23'(slope_reg) * 23'(frac_reg);
        a_next = lo_reg + oct_t'(prod[22:FRAC_BITS]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lk_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else if (en)
        begin
            lk_valid_reg <= valid_in;
            valid_reg    <= lk_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg       <= lo_next;
            slope_reg    <= slope_next;
            frac_reg     <= frac;
            lk_flags_reg <= flags_in;
            a_reg        <= a_next;
            flags_reg    <= lk_flags_reg;
        end
    end

endmodule

FILE: rtl/fixed_point_atan2_table_top.sv
// ----------------------------------------------------------------------------
// fixed_point_atan2_table_top: four-quadrant arctangent, table interpolation
// Streams sine/cosine pairs in and angles out, one transaction per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: one sine/cosine pair per transaction.
//   Master channel m_axis_*: one angle per input, in input order;
//   16384 units make a full turn, results span -8192..8192, (0,0) gives 0.
//   Stages from accepted input to m_axis_tvalid:
//   1 fold stage, 15 division cells, 2 interpolation stages, 1 output stage.
//   Throughput: one transaction per cycle, set by the division chain, whose
//   cells each resolve one quotient bit and pass their word on every cycle.
//   When the receiver stalls with a result waiting, the whole chain holds and
//   s_axis_tready drops; it rises again as soon as the result is taken.
//   Reset clears all valid flags; no result is presented until new input
//   arrives, and the block takes input in the first cycle after reset.
// ----------------------------------------------------------------------------
module fixed_point_atan2_table_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] sine_value, [31:16] cosine_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [14:0] signed angle, [15] reserved, driven 0
);
    import fat2_pkg::*;

    logic        en;

    logic        valid_chain [0:DIV_STEPS];
    mag_t        rem_chain   [0:DIV_STEPS];
    mag_t        x_chain     [0:DIV_STEPS];
    quot_t       q_chain     [0:DIV_STEPS];
    fat2_flags_t flags_chain [0:DIV_STEPS];

    logic        ip_valid;
    oct_t        ip_a;
    fat2_flags_t ip_flags;

    logic signed [14:0] a_ext;
    logic signed [14:0] base;
    logic signed [14:0] angle_next;
    logic signed [14:0] angle_reg;
    logic               out_valid_reg;

    // advance the whole chain unless a finished result is held
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    fat2_fold u_fold (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_axis_tvalid),
        .sine_value   (s_axis_tdata[15:0]),
        .cosine_value (s_axis_tdata[31:16]),
        .valid_reg    (valid_chain[0]),
        .y_reg        (rem_chain[0]),
        .x_reg        (x_chain[0]),
        .flags_reg    (flags_chain[0])
    );

    assign q_chain[0] = '0;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        fat2_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (valid_chain[i]),
            .rem_in    (rem_chain[i]),
            .x_in      (x_chain[i]),
            .q_in      (q_chain[i]),
            .flags_in  (flags_chain[i]),
            .valid_reg (valid_chain[i+1]),
            .rem_reg   (rem_chain[i+1]),
            .x_reg     (x_chain[i+1]),
            .q_reg     (q_chain[i+1]),
            .flags_reg (flags_chain[i+1])
        );
    end

    fat2_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (valid_chain[DIV_STEPS]),
        .t_in      (q_chain[DIV_STEPS]),
        .flags_in  (flags_chain[DIV_STEPS]),
        .valid_reg (ip_valid),
        .a_reg     (ip_a),
        .flags_reg (ip_flags)
    );

    // unfold the octant angle by quadrant
    always_comb
    begin
        a_ext = {3'b000, ip_a};
        if (ip_flags.cneg)
        begin
            base = ip_flags.swap ? 15'(QUARTER_TURN) + a_ext : 15'(HALF_TURN) - a_ext;
        end
        else
        begin
            base = ip_flags.swap ? 15'(QUARTER_TURN) - a_ext : a_ext;
        end
        angle_next = ip_flags.sneg ? -base : base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ip_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, angle_reg};

`ifndef NO_ASSERTIONS
    // final division remainder stays below twice the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_chain[DIV_STEPS] && !flags_chain[DIV_STEPS].zero
        |-> ({1'b0, rem_chain[DIV_STEPS]} < {x_chain[DIV_STEPS], 1'b0}))
        else $error("division remainder out of range");

    // octant angle never exceeds one eighth of a turn
    a_oct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ip_valid |-> (ip_a <= oct_t'(QUARTER_TURN / 2)))
        else $error("octant angle out of range");

    // delivered angle lies within half a turn either way
    a_angle_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((angle_reg <= 15'sd8192) && (angle_reg >= -15'sd8192)))
        else $error("angle out of range");
`endif

endmodule
